// ----- sv/desk_height_bang_bang_controller_top_defines.svh -----
// Assertion macros used by the desk height controller top level.
`ifndef DESK_HEIGHT_BANG_BANG_CONTROLLER_TOP_DEFINES_SVH
`define DESK_HEIGHT_BANG_BANG_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DHC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define DHC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/dhc_pkg.sv -----
// Types and constants of the desk height controller.
package dhc_pkg;

  localparam int unsigned POS_W = 15;

  // echo_us * 0.017 cm * 16, in Q16
  localparam logic [14:0] ECHO_SCALE = 15'd17826;

  localparam logic [1:0] KIND_LOOP   = 2'd0;
  localparam logic [1:0] KIND_TARGET = 2'd1;
  localparam logic [1:0] KIND_PRESS  = 2'd2;

  localparam logic [1:0] MOTION_STOP = 2'd0;
  localparam logic [1:0] MOTION_UP   = 2'd1;
  localparam logic [1:0] MOTION_DOWN = 2'd2;

  typedef enum logic [1:0] {
    CFG_ACTIVE_TOL = 2'd0,
    CFG_IDLE_TOL   = 2'd1,
    CFG_STUCK_LIM  = 2'd2,
    CFG_POLL_IVL   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [31:0]        now_ms;
    logic [15:0]        echo_us;
    logic [14:0]        target_set;
    logic signed [31:0] press_ms;
  } in_t;

  typedef struct packed {
    logic        drive_up;
    logic        drive_down;
    logic        report;
    logic [14:0] position;
    logic [14:0] target;
    logic [1:0]  motion;
    logic        manual_active;
    logic [7:0]  move_count;
  } out_t;

  typedef struct packed {
    logic [9:0]  active_tol;
    logic [9:0]  idle_tol;
    logic [7:0]  stuck_limit;
    logic [19:0] poll_ivl;
  } cfg_t;

  function automatic logic [POS_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                                input logic [POS_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ----- sv/desk_height_bang_bang_controller_top.sv -----
// Top level of the desk height controller: request pipeline and register file.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+-----------------------------
//  in_     | input     | in_valid/in_stall | dhc_pkg::in_t  (one request)
//  out_    | output    | out_valid/out_stall| dhc_pkg::out_t (one result)
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One request per cycle sustained while out_stall is low; each request is
// registered in the input register and then in the result register. The height
// conversion runs ahead of the input register, and the mode update sits between
// the input register and the result register. The state update is a loop on
// the controller registers. Reset (rst_n low, synchronous) clears all controller
// state, loads the register defaults and empties both pipeline stages.
// A stall on the result side backs up through the stage register; in_stall
// rises only when that stage holds a request that cannot move on.
// cfg_ready is always high; write registers only while no request is in flight.
module desk_height_bang_bang_controller_top #(
  parameter int POSITION_BITS = 15
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  dhc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output dhc_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [19:0]   cfg_data
);
  import dhc_pkg::*;

  `include "desk_height_bang_bang_controller_top_defines.svh"

  cfg_t             cfg_r;
  in_t              s1_item_r;
  logic [POS_W-1:0] s1_pos_r;
  logic             s1_valid_r, s1_valid_nxt;
  out_t             out_data_r;
  logic             out_valid_r, out_valid_nxt;
  logic [POS_W-1:0] sense_pos;
  out_t             core_res;
  logic             out_take;
  logic             adv;
  logic             in_take;

  assign cfg_ready = 1'b1;

  // register file: defaults on reset, one write per accepted cfg request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_tol  <= 10'd16;
      cfg_r.idle_tol    <= 10'd32;
      cfg_r.stuck_limit <= 8'd100;
      cfg_r.poll_ivl    <= 20'd4000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ACTIVE_TOL: cfg_r.active_tol  <= cfg_data[9:0];
        CFG_IDLE_TOL:   cfg_r.idle_tol    <= cfg_data[9:0];
        CFG_STUCK_LIM:  cfg_r.stuck_limit <= cfg_data[7:0];
        CFG_POLL_IVL:   cfg_r.poll_ivl    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sensor conversion depends on the echo alone, so do it ahead of the state loop
  dhc_sense #(.POSITION_BITS(POSITION_BITS)) u_sense (
    .echo_us (in_data.echo_us),
    .pos     (sense_pos)
  );

  // output slot can accept when empty or being drained this cycle
  assign out_take = !out_valid_r || !out_stall;
  assign adv      = s1_valid_r && out_take;
  assign in_stall = s1_valid_r && !out_take;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !adv);
  assign out_valid_nxt = adv || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers: hold while stalled, load on handshake
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_data;
      s1_pos_r  <= sense_pos;
    end
    if (adv) begin
      out_data_r <= core_res;
    end
  end

  // mode update; controller state advances with the request
  dhc_core #(.POSITION_BITS(POSITION_BITS)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .item      (s1_item_r),
    .sense_pos (s1_pos_r),
    .cfg       (cfg_r),
    .res       (core_res)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `DHC_ASSERT_NOW(a_drive_excl, out_valid_r,
                  !(out_data_r.drive_up && out_data_r.drive_down), "both drives active")
  `DHC_ASSERT_NOW(a_stall_full, in_stall, s1_valid_r, "input stalled with empty stage")
  `DHC_ASSERT_NEXT(a_adv_out, adv, out_valid_r, "advanced request lost")
  `DHC_ASSERT_NOW(a_moves_active, out_valid_r && out_data_r.move_count != 8'd0,
                  out_data_r.motion != MOTION_STOP, "move count without active motion")

endmodule

// ----- sv/dhc_sense.sv -----
// Echo width to height conversion with saturation.
module dhc_sense #(
  parameter int POSITION_BITS = 15
) (
  input  logic [15:0]              echo_us,
  output logic [dhc_pkg::POS_W-1:0] pos
);
  import dhc_pkg::*;

  localparam logic [31:0] PosMax = 32'((64'd1 << POSITION_BITS) - 64'd1);

  logic [30:0]      product;
  logic [POS_W-1:0] raw;

  assign product = 31'(echo_us) * 31'(ECHO_SCALE);
  assign raw     = product[30:16];
  assign pos     = ({17'd0, raw} > PosMax) ? PosMax[POS_W-1:0] : raw;

endmodule

// ----- sv/dhc_core.sv -----
// Controller state and per-request mode update.
module dhc_core #(
  parameter int POSITION_BITS = 15
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  dhc_pkg::in_t              item,
  input  logic [dhc_pkg::POS_W-1:0] sense_pos,
  input  dhc_pkg::cfg_t             cfg,
  output dhc_pkg::out_t             res
);
  import dhc_pkg::*;

  localparam logic [31:0] PosMax = 32'((64'd1 << POSITION_BITS) - 64'd1);

  logic [POS_W-1:0] meas_r, meas_nxt;
  logic [POS_W-1:0] goal_r, goal_nxt;
  logic             active_r, active_nxt;
  logic             manual_r, manual_nxt;
  logic [31:0]      deadline_r, deadline_nxt;
  logic             press_up_r, press_up_nxt;
  logic [31:0]      last_poll_r, last_poll_nxt;
  logic [7:0]       moves_r, moves_nxt;
  logic             up_r, up_nxt;
  logic             down_r, down_nxt;
  logic             report;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meas_r      <= '0;
      goal_r      <= '0;
      active_r    <= 1'b0;
      manual_r    <= 1'b0;
      deadline_r  <= '0;
      press_up_r  <= 1'b0;
      last_poll_r <= '0;
      moves_r     <= '0;
      up_r        <= 1'b0;
      down_r      <= 1'b0;
    end else if (adv) begin
      meas_r      <= meas_nxt;
      goal_r      <= goal_nxt;
      active_r    <= active_nxt;
      manual_r    <= manual_nxt;
      deadline_r  <= deadline_nxt;
      press_up_r  <= press_up_nxt;
      last_poll_r <= last_poll_nxt;
      moves_r     <= moves_nxt;
      up_r        <= up_nxt;
      down_r      <= down_nxt;
    end
  end

  always_comb begin
    logic [POS_W-1:0] goal_tmp;
    logic [31:0]      late;
    logic [31:0]      mag;
    meas_nxt      = meas_r;
    goal_nxt      = goal_r;
    active_nxt    = active_r;
    manual_nxt    = manual_r;
    deadline_nxt  = deadline_r;
    press_up_nxt  = press_up_r;
    last_poll_nxt = last_poll_r;
    moves_nxt     = moves_r;
    up_nxt        = up_r;
    down_nxt      = down_r;
    report        = 1'b0;
    goal_tmp      = goal_r;
    late          = item.now_ms - deadline_r;
    mag           = item.press_ms[31] ? (32'd0 - item.press_ms) : item.press_ms;
    case (item.kind)
      KIND_LOOP: begin
        if (active_r) begin
          // drive toward the goal; snap the goal when the desk stops following
          report   = 1'b1;
          meas_nxt = sense_pos;
          if (moves_r > cfg.stuck_limit) goal_tmp = sense_pos;
          goal_nxt = goal_tmp;
          if (abs_diff(goal_tmp, sense_pos) < {5'd0, cfg.active_tol}) begin
            up_nxt     = 1'b0;
            down_nxt   = 1'b0;
            active_nxt = 1'b0;
            moves_nxt  = '0;
          end else begin
            up_nxt   = goal_tmp > sense_pos;
            down_nxt = !(goal_tmp > sense_pos);
            if (moves_r != 8'hFF) moves_nxt = moves_r + 8'd1;
          end
        end else if (manual_r) begin
          report = 1'b1;
          if (deadline_r == 32'd0 || (late != 32'd0 && !late[31])) begin
            manual_nxt = 1'b0;
            up_nxt     = 1'b0;
            down_nxt   = 1'b0;
          end else begin
            up_nxt   = press_up_r;
            down_nxt = !press_up_r;
          end
        end else if ((item.now_ms - last_poll_r) >= {12'd0, cfg.poll_ivl}) begin
          last_poll_nxt = item.now_ms;
          meas_nxt      = sense_pos;
          goal_nxt      = sense_pos;
          report        = abs_diff(sense_pos, meas_r) > {5'd0, cfg.idle_tol};
        end
      end
      KIND_TARGET: begin
        if (item.target_set != '0) begin
          goal_nxt   = ({17'd0, item.target_set} > PosMax) ? PosMax[POS_W-1:0]
                                                           : item.target_set;
          active_nxt = 1'b1;
        end
      end
      KIND_PRESS: begin
        if (item.press_ms != '0) begin
          deadline_nxt = item.now_ms + mag;
          press_up_nxt = !item.press_ms[31];
          manual_nxt   = 1'b1;
        end
      end
      default: begin
      end
    endcase

    res.drive_up      = up_nxt;
    res.drive_down    = down_nxt;
    res.report        = report;
    res.position      = meas_nxt;
    res.target        = goal_nxt;
    res.motion        = !active_nxt ? MOTION_STOP :
                        (goal_nxt > meas_nxt) ? MOTION_UP : MOTION_DOWN;
    res.manual_active = manual_nxt;
    res.move_count    = moves_nxt;
  end

endmodule
